### hw/rtl/bqd_pkg.sv
// bqd_pkg: shared types, constants and codes of the biquad filter unit
// no dependencies; imported by every other file of the block
`timescale 1ns / 1ps

package bqd_pkg;

  // sample and coefficient formats
  localparam int DATA_W  = 32;            // Q16.16 samples
  localparam int COEF_W  = 32;            // Q4.28 coefficients
  localparam int OP_W    = 2;
  localparam int IDX_W   = 3;
  localparam int ORD_W   = 2;
  localparam int PROD_W  = 2 * DATA_W;    // Q20.44 products
  localparam int ACC_W   = PROD_W + 3;    // sum of five products, exact
  localparam int SUM_W   = COEF_W + 2;    // sum of three coefficients
  localparam int FRAC_C  = 28;
  localparam int FRAC_S  = 16;
  localparam int DEN_TOL = 268;           // 1e-6 in Q4.28 units

  // iterative divider sizes
  localparam int DIV_NW  = 51;            // dividend, 2|n| + |d|
  localparam int DIV_DW  = 34;            // divisor, 2|d|
  localparam int DIV_CW  = 6;

  localparam logic signed [DATA_W-1:0] SAT_MAX  = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] SAT_MIN  = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] GAIN_ONE = 32'sh0001_0000;
  localparam logic signed [COEF_W-1:0] A0_RESET = 32'sh1000_0000;

  localparam logic signed [ACC_W-1:0] HALF_Q28 = ACC_W'(1) << (FRAC_C - 1);
  localparam logic signed [ACC_W-1:0] HALF_Q16 = ACC_W'(1) << (FRAC_S - 1);
  localparam logic [DIV_NW-1:0] Q_POS_LIM = DIV_NW'(64'h7fff_ffff);
  localparam logic [DIV_NW-1:0] Q_NEG_LIM = DIV_NW'(64'h8000_0000);

  // input word operation codes
  typedef enum logic [OP_W-1:0] {
    OP_STEP    = 2'd0,
    OP_RST_IN  = 2'd1,
    OP_RST_OUT = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  // configuration register map
  typedef enum logic [IDX_W-1:0] {
    REG_NUM0    = 3'd0,
    REG_NUM1    = 3'd1,
    REG_NUM2    = 3'd2,
    REG_DEN0    = 3'd3,
    REG_DEN1    = 3'd4,
    REG_DEN2    = 3'd5,
    REG_ORDER   = 3'd6,
    REG_DES_ERR = 3'd7
  } cfg_idx_t;

  // multiplier operand pairs, the first five in step order
  typedef enum logic [2:0] {
    SEL_B0_S   = 3'd0,
    SEL_B1_IH0 = 3'd1,
    SEL_A1_OH0 = 3'd2,
    SEL_B2_IH1 = 3'd3,
    SEL_A2_OH1 = 3'd4,
    SEL_S_G    = 3'd5
  } mul_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_DRAIN,
    S_ROUND,
    S_GSETUP,
    S_GDIV,
    S_GSAT,
    S_QSETUP,
    S_QDIV,
    S_QSAT,
    S_QZERO,
    S_FIN
  } state_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a0;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic [ORD_W-1:0]         order;
    logic                     design_error;
  } coef_t;

  // controller to datapath
  typedef struct packed {
    logic     load;
    logic     mul_go;
    mul_sel_t mul_sel;
    logic     round;
    logic     gain_start;
    logic     gain_sat;
    logic     quo_start;
    logic     quo_sat;
    logic     quo_zero;
    logic     commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic small_den;
    logic g_zero;
    logic div_done;
  } sts_t;

endpackage

### hw/rtl/bqd_if.sv
// bqd_if: valid/ready channel interfaces of the biquad filter unit
// depends on bqd_pkg for field widths
`timescale 1ns / 1ps

// input word: operation and sample
interface bqd_in_if import bqd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic signed [DATA_W-1:0] sample;

  modport source (output valid, opcode, sample, input ready);
  modport sink (input valid, opcode, sample, output ready);
endinterface

// result word: filter output and clip flag
interface bqd_out_if import bqd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] filtered;
  logic                     saturated;

  modport source (output valid, filtered, saturated, input ready);
  modport sink (input valid, filtered, saturated, output ready);
endinterface

// configuration register writes
interface bqd_cfg_if import bqd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [COEF_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/bqd_div.sv
// bqd_div: unsigned restoring divider, one quotient bit per cycle
// depends on bqd_pkg for operand widths
`timescale 1ns / 1ps

module bqd_div import bqd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              done,
  output logic [DIV_NW-1:0] quot
);

  logic              busy;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_NW-1:0] nq;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dd;
  logic [DIV_DW:0]   trial;
  logic              qbit;

  // shift in the next dividend bit and try the subtract
  always_comb begin
    trial = {rem, nq[DIV_NW-1]};
    qbit  = (trial >= {1'b0, dd});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CW'(DIV_NW - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) busy <= 1'b0;
      end
    end
  end

  // quotient bits shift into the dividend register; the partial remainder has its own
  always_ff @(posedge clk) begin
    if (start) begin
      nq  <= num;
      rem <= '0;
      dd  <= den;
    end else if (busy) begin
      nq <= {nq[DIV_NW-2:0], qbit};
      if (qbit) rem <= DIV_DW'(trial - {1'b0, dd});
      else      rem <= trial[DIV_DW-1:0];
    end
  end

  assign quot = nq;

endmodule

### hw/rtl/bqd_dpath.sv
// bqd_dpath: histories, shared multiplier, accumulator, rounding and gain
// depends on bqd_pkg and bqd_div
`timescale 1ns / 1ps

module bqd_dpath import bqd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [OP_W-1:0]          in_opcode,
  input  logic signed [DATA_W-1:0] in_sample,
  input  coef_t                    coef,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  output logic signed [DATA_W-1:0] filtered,
  output logic                     saturated
);

  op_t                      op_reg;
  logic signed [DATA_W-1:0] s_reg;
  logic signed [DATA_W-1:0] ih [2];
  logic signed [DATA_W-1:0] oh [2];
  logic signed [DATA_W-1:0] y_reg;
  logic signed [DATA_W-1:0] u_reg;
  logic signed [DATA_W-1:0] g_reg;
  logic                     flag;
  logic signed [PROD_W-1:0] prod;
  logic                     prod_vld;
  logic                     prod_sub;
  logic signed [ACC_W-1:0]  acc;
  logic                     div_neg;

  logic signed [DATA_W-1:0] ma, mb;
  logic                     m_sub;
  logic signed [ACC_W-1:0]  prod_x;
  logic signed [ACC_W-1:0]  rnd;
  logic                     rnd_ovf;
  logic signed [DATA_W-1:0] rnd_val;
  logic signed [SUM_W-1:0]  ns, ds;
  logic [SUM_W-1:0]         ns_mag, ds_mag;
  logic [DATA_W:0]          s_ext, g_ext;
  logic [DATA_W:0]          s_mag, g_mag;
  logic [DIV_NW-1:0]        div_num;
  logic [DIV_DW-1:0]        div_den;
  logic                     div_start;
  logic                     div_done;
  logic [DIV_NW-1:0]        div_q;
  logic signed [DATA_W-1:0] qs_val;
  logic                     qs_flag;
  logic signed [DATA_W-1:0] zero_val;
  logic signed [DATA_W-1:0] hu, hy;

  // multiplier operand select
  always_comb begin
    ma    = coef.b0;
    mb    = s_reg;
    m_sub = 1'b0;
    case (cmd.mul_sel)
      SEL_B0_S:   begin ma = coef.b0; mb = s_reg; end
      SEL_B1_IH0: begin ma = coef.b1; mb = ih[0]; end
      SEL_A1_OH0: begin ma = coef.a1; mb = oh[0]; m_sub = 1'b1; end
      SEL_B2_IH1: begin ma = coef.b2; mb = ih[1]; end
      SEL_A2_OH1: begin ma = coef.a2; mb = oh[1]; m_sub = 1'b1; end
      SEL_S_G:    begin ma = s_reg;   mb = g_reg; end
      default:    begin ma = coef.b0; mb = s_reg; end
    endcase
  end

  assign prod_x = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};

  // round half up at the binary point of the operation, then clip
  always_comb begin
    if (op_reg == OP_STEP) rnd = (acc + HALF_Q28) >>> FRAC_C;
    else                   rnd = (acc + HALF_Q16) >>> FRAC_S;
    rnd_ovf = !((&rnd[ACC_W-1:DATA_W-1]) || !(|rnd[ACC_W-1:DATA_W-1]));
    if (rnd_ovf) rnd_val = rnd[ACC_W-1] ? SAT_MIN : SAT_MAX;
    else         rnd_val = rnd[DATA_W-1:0];
  end

  // dc gain sums over all three taps
  always_comb begin
    ns = {{2{coef.b0[COEF_W-1]}}, coef.b0} + {{2{coef.b1[COEF_W-1]}}, coef.b1}
       + {{2{coef.b2[COEF_W-1]}}, coef.b2};
    ds = {{2{coef.a0[COEF_W-1]}}, coef.a0} + {{2{coef.a1[COEF_W-1]}}, coef.a1}
       + {{2{coef.a2[COEF_W-1]}}, coef.a2};
    ns_mag = ns[SUM_W-1] ? SUM_W'(-ns) : SUM_W'(ns);
    ds_mag = ds[SUM_W-1] ? SUM_W'(-ds) : SUM_W'(ds);
    s_ext  = {s_reg[DATA_W-1], s_reg};
    g_ext  = {g_reg[DATA_W-1], g_reg};
    s_mag  = s_ext[DATA_W] ? (DATA_W + 1)'(-s_ext) : s_ext;
    g_mag  = g_ext[DATA_W] ? (DATA_W + 1)'(-g_ext) : g_ext;
  end

  // divider operands: round to nearest as (2|n| + |d|) / (2|d|)
  always_comb begin
    div_start = cmd.gain_start || cmd.quo_start;
    if (cmd.gain_start) begin
      div_num = (DIV_NW'(ns_mag) << (FRAC_S + 1)) + DIV_NW'(ds_mag);
      div_den = DIV_DW'(ds_mag) << 1;
    end else begin
      div_num = (DIV_NW'(s_mag) << (FRAC_S + 1)) + DIV_NW'(g_mag);
      div_den = DIV_DW'(g_mag) << 1;
    end
  end

  bqd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  // signed quotient with clipping
  always_comb begin
    qs_flag = 1'b0;
    qs_val  = div_q[DATA_W-1:0];
    if (div_neg) begin
      if (div_q > Q_NEG_LIM) begin
        qs_val  = SAT_MIN;
        qs_flag = 1'b1;
      end else begin
        qs_val = DATA_W'(32'd0 - div_q[DATA_W-1:0]);
      end
    end else if (div_q > Q_POS_LIM) begin
      qs_val  = SAT_MAX;
      qs_flag = 1'b1;
    end
  end

  // zero gain: extreme of the target's sign, or zero for a zero target
  always_comb begin
    if (s_reg == '0)          zero_val = '0;
    else if (s_reg[DATA_W-1]) zero_val = SAT_MIN;
    else                      zero_val = SAT_MAX;
  end

  // values loaded into both history taps on a reset operation
  always_comb begin
    hu = s_reg;
    hy = y_reg;
    if (op_reg == OP_RST_OUT) begin
      hu = u_reg;
      hy = s_reg;
    end
  end

  assign sts.small_den = (ds <= DEN_TOL) && (ds >= -DEN_TOL);
  assign sts.g_zero    = (g_reg == '0);
  assign sts.div_done  = div_done;

  // product pipeline valid
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= cmd.mul_go;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_reg <= op_t'(in_opcode);
      s_reg  <= in_sample;
      acc    <= '0;
      flag   <= 1'b0;
    end else begin
      if (prod_vld) begin
        if (prod_sub) acc <= acc - prod_x;
        else          acc <= acc + prod_x;
      end
      if (cmd.round) begin
        y_reg <= rnd_val;
        flag  <= flag | rnd_ovf;
      end
      if (cmd.gain_sat) begin
        g_reg <= sts.small_den ? GAIN_ONE : qs_val;
        flag  <= flag | (!sts.small_den && qs_flag);
      end
      if (cmd.quo_sat) begin
        u_reg <= qs_val;
        flag  <= flag | qs_flag;
      end
      if (cmd.quo_zero) begin
        u_reg <= zero_val;
        flag  <= 1'b1;
      end
    end
    if (cmd.mul_go) begin
      prod     <= ma * mb;
      prod_sub <= m_sub;
    end
    if (cmd.gain_start) div_neg <= ns[SUM_W-1] ^ ds[SUM_W-1];
    if (cmd.quo_start)  div_neg <= s_reg[DATA_W-1] ^ g_reg[DATA_W-1];
  end

  // histories
  always_ff @(posedge clk) begin
    if (rst) begin
      ih[0] <= '0;
      ih[1] <= '0;
      oh[0] <= '0;
      oh[1] <= '0;
    end else if (cmd.commit) begin
      case (op_reg) inside
        OP_STEP: begin
          ih[1] <= ih[0];
          ih[0] <= s_reg;
          oh[1] <= oh[0];
          oh[0] <= y_reg;
        end
        OP_RST_IN, OP_RST_OUT: begin
          if (coef.design_error) begin
            ih[0] <= '0;
            ih[1] <= '0;
            oh[0] <= '0;
            oh[1] <= '0;
          end else begin
            ih[0] <= hu;
            ih[1] <= hu;
            oh[0] <= hy;
            oh[1] <= hy;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      case (op_reg) inside
        OP_STEP: begin
          filtered  <= y_reg;
          saturated <= flag;
        end
        OP_RST_IN, OP_RST_OUT: begin
          filtered  <= coef.design_error ? '0 : hy;
          saturated <= coef.design_error ? 1'b0 : flag;
        end
        default: begin
          filtered  <= oh[0];
          saturated <= 1'b0;
        end
      endcase
    end
  end

endmodule

### hw/rtl/bqd_ctrl.sv
// bqd_ctrl: sequencer for steps, dc gain and the reset operations
// depends on bqd_pkg; drives bqd_dpath through cmd_t
`timescale 1ns / 1ps

module bqd_ctrl import bqd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [OP_W-1:0]  in_opcode,
  output logic             out_valid,
  input  logic             out_ready,
  input  logic [ORD_W-1:0] order,
  input  logic             design_error,
  input  sts_t             sts,
  output cmd_t             cmd
);

  state_t     state, state_next;
  op_t        op_reg;
  logic [2:0] cnt;
  logic [2:0] last_idx;
  logic [1:0] ord_c;
  logic       out_free;

  // order three runs as order two; reset to input needs one product
  assign ord_c    = (order == 2'd3) ? 2'd2 : order;
  assign last_idx = (op_reg == OP_RST_IN) ? 3'd0 : {ord_c, 1'b0};
  assign out_free = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (op_t'(in_opcode)) inside
            OP_STEP:               state_next = S_MUL;
            OP_RST_IN, OP_RST_OUT: state_next = design_error ? S_FIN : S_GSETUP;
            default:               state_next = S_FIN;
          endcase
        end
      end
      S_MUL:    if (cnt == last_idx) state_next = S_DRAIN;
      S_DRAIN:  state_next = S_ROUND;
      S_ROUND:  state_next = S_FIN;
      S_GSETUP: state_next = sts.small_den ? S_GSAT : S_GDIV;
      S_GDIV:   if (sts.div_done) state_next = S_GSAT;
      S_GSAT:   state_next = (op_reg == OP_RST_IN) ? S_MUL : S_QSETUP;
      S_QSETUP: state_next = sts.g_zero ? S_QZERO : S_QDIV;
      S_QDIV:   if (sts.div_done) state_next = S_QSAT;
      S_QSAT:   state_next = S_FIN;
      S_QZERO:  state_next = S_FIN;
      S_FIN:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // command outputs; no word is taken while in reset
  always_comb begin
    cmd         = '0;
    cmd.mul_sel = SEL_B0_S;
    in_ready    = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = !rst;
        cmd.load = in_valid && !rst;
      end
      S_MUL: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = (op_reg == OP_RST_IN) ? SEL_S_G : mul_sel_t'(cnt);
      end
      S_ROUND:  cmd.round      = 1'b1;
      S_GSETUP: cmd.gain_start = !sts.small_den;
      S_GSAT:   cmd.gain_sat   = 1'b1;
      S_QSETUP: cmd.quo_start  = !sts.g_zero;
      S_QSAT:   cmd.quo_sat    = 1'b1;
      S_QZERO:  cmd.quo_zero   = 1'b1;
      S_FIN:    cmd.commit     = out_free;
      default: begin
      end
    endcase
  end

  // state, tap counter, latched operation, result word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      op_reg    <= OP_STEP;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state == S_MUL) ? cnt + 3'd1 : 3'd0;
      if (cmd.load) op_reg <= op_t'(in_opcode);
      if (cmd.commit)     out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // divider completion is only seen while waiting for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> (state == S_GDIV) || (state == S_QDIV))
    else $error("divider finished outside a wait state");

  // the tap counter never runs past the last product
  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (cnt <= last_idx))
    else $error("tap counter beyond filter order");

  // a committed result is offered on the next cycle
  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit did not raise result valid");

endmodule

### hw/rtl/biquad_iir_filter_with_dc_reset_unit.sv
// Biquad IIR filter (direct form I) with dc-gain history reset.
// Step: one product per cycle on the shared 32x32 multiplier, then drain and
//   rounding; the next word is taken once the result has been committed.
// Reset to input and reset to output use the bit-serial divider for the dc gain;
//   reset to output also uses it for y/G.
// Synchronous active-high rst clears histories and loads register defaults.
`timescale 1ns / 1ps

module biquad_iir_filter_with_dc_reset_unit import bqd_pkg::*; (
  input logic      clk,
  input logic      rst,
  bqd_cfg_if.sink  cfg,
  bqd_in_if.sink   din,
  bqd_out_if.source dout
);

  coef_t coef;
  cmd_t  cmd;
  sts_t  sts;

  // configuration registers, ready whenever out of reset
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.b0           <= '0;
      coef.b1           <= '0;
      coef.b2           <= '0;
      coef.a0           <= A0_RESET;
      coef.a1           <= '0;
      coef.a2           <= '0;
      coef.order        <= '0;
      coef.design_error <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_idx_t'(cfg.index))
        REG_NUM0:    coef.b0           <= cfg.data;
        REG_NUM1:    coef.b1           <= cfg.data;
        REG_NUM2:    coef.b2           <= cfg.data;
        REG_DEN0:    coef.a0           <= cfg.data;
        REG_DEN1:    coef.a1           <= cfg.data;
        REG_DEN2:    coef.a2           <= cfg.data;
        REG_ORDER:   coef.order        <= cfg.data[ORD_W-1:0];
        REG_DES_ERR: coef.design_error <= cfg.data[0];
      endcase
    end
  end

  bqd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (din.valid),
    .in_ready     (din.ready),
    .in_opcode    (din.opcode),
    .out_valid    (dout.valid),
    .out_ready    (dout.ready),
    .order        (coef.order),
    .design_error (coef.design_error),
    .sts          (sts),
    .cmd          (cmd)
  );

  bqd_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_opcode (din.opcode),
    .in_sample (din.sample),
    .coef      (coef),
    .cmd       (cmd),
    .sts       (sts),
    .filtered  (dout.filtered),
    .saturated (dout.saturated)
  );

endmodule
